### sv/olte_pkg.sv
`default_nettype none
// ============================================================================
// olte_pkg
// shared types, codes and defaults of the ordered list table engine
// ============================================================================
package olte_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_ELEM_WIDTH = 32;

    localparam int ACTION_W = 4;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 6;
    localparam int LEN_W    = 7;

    localparam logic [ACTION_W-1:0] A_READ      = 4'd0;
    localparam logic [ACTION_W-1:0] A_FIND      = 4'd1;
    localparam logic [ACTION_W-1:0] A_MODIFY    = 4'd2;
    localparam logic [ACTION_W-1:0] A_INS_FRONT = 4'd3;
    localparam logic [ACTION_W-1:0] A_INS_BACK  = 4'd4;
    localparam logic [ACTION_W-1:0] A_INS_AT    = 4'd5;
    localparam logic [ACTION_W-1:0] A_DEL_AT    = 4'd6;
    localparam logic [ACTION_W-1:0] A_DEL_VALUE = 4'd7;
    localparam logic [ACTION_W-1:0] A_CLEAR     = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value_out;
        logic [FIDX_W-1:0]         found_index;
        logic [LEN_W-1:0]          list_length;
        logic                      is_empty;
    } t_rsp;

endpackage
`default_nettype wire

### sv/olte_cell.sv
`default_nettype none
// ============================================================================
// olte_cell
// one list slot: holds an element, compares it with the search key and
// shifts toward or away from its neighbors on insert and delete
// ============================================================================
module olte_cell #(
    parameter int ELEM_WIDTH = olte_pkg::DEF_ELEM_WIDTH,
    parameter int CNT_W      = 7,
    parameter int IDX        = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_match_en,
    input  wire logic [ELEM_WIDTH-1:0] i_key,
    input  wire logic [CNT_W-1:0]      i_count,
    input  wire olte_pkg::t_cell_op    i_op,
    input  wire logic [CNT_W-1:0]      i_tgt,
    input  wire logic [ELEM_WIDTH-1:0] i_wdata,
    input  wire logic [ELEM_WIDTH-1:0] i_left,
    input  wire logic [ELEM_WIDTH-1:0] i_right,
    output logic [ELEM_WIDTH-1:0]      o_value,
    output logic                       o_match
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

    logic [ELEM_WIDTH-1:0] r_value;
    logic [ELEM_WIDTH-1:0] n_value;
    logic                  r_match;

    always_comb begin
        n_value = r_value;
        case (i_op)
            olte_pkg::OP_WRITE: begin
                if (IDX_C == i_tgt) begin
                    n_value = i_wdata;
                end
            end
            olte_pkg::OP_INSERT: begin
                if (IDX_C == i_tgt) begin
                    n_value = i_wdata;
                end else if (IDX_C > i_tgt && IDX_C <= i_count) begin
                    n_value = i_left;
                end
            end
            olte_pkg::OP_DELETE: begin
                if (IDX_C >= i_tgt && IDX_P1 < i_count) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_match_en) begin
            r_match <= (r_value == i_key) && (IDX_C < i_count);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule
`default_nettype wire

### sv/ordered_list_table_engine.sv
`default_nettype none
// ============================================================================
// ordered_list_table_engine
// fixed-capacity ordered list of signed words built from a row of cells
// ============================================================================
// usage
//   request channel i_valid / o_stall / i_in carries action, 1-based position
//   and value; one transaction is taken only while the engine is idle
//   response channel o_valid / i_stall / o_out returns exactly one result
//   per request: status, value, found index, length and empty flag
//   steps: a request taken in S_IDLE goes to S_LOCATE, then to S_APPLY,
//   whose write of the output register raises o_valid; the cells compare
//   at the accept edge, the first-match search runs in S_LOCATE, and the
//   cell row shifts in S_APPLY; no new request is taken until S_APPLY ends
//   a waiting result does not block the next request; a stalled response
//   holds the engine in its last step until the output register frees up
//   reset empties the list; element storage keeps no reset value and only
//   entries below the length are ever returned
// ============================================================================
module ordered_list_table_engine #(
    parameter int CAPACITY   = olte_pkg::DEF_CAPACITY,
    parameter int ELEM_WIDTH = olte_pkg::DEF_ELEM_WIDTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire olte_pkg::t_req i_in,
    output logic                o_valid,
    input  wire logic           i_stall,
    output olte_pkg::t_rsp      o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > olte_pkg::POS_W) ? CNT_W : olte_pkg::POS_W;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOCATE = 3'b010,
        S_APPLY  = 3'b100
    } t_state;

    t_state                r_state;
    olte_pkg::t_req        r_req;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_new_count;
    logic [CNT_W-1:0]      r_tgt;
    logic [CNT_W-1:0]      r_fidx;
    olte_pkg::t_cell_op    r_op;
    logic [olte_pkg::STATUS_W-1:0] r_status;
    logic                  r_rd;
    logic                  r_out_valid;
    olte_pkg::t_rsp        r_out;

    logic [CNT_W-1:0]      n_new_count;
    logic [CNT_W-1:0]      n_tgt;
    logic [CNT_W-1:0]      n_fidx;
    olte_pkg::t_cell_op    n_op;
    logic [olte_pkg::STATUS_W-1:0] n_status;
    logic                  n_rd;

    logic                  w_accept;
    logic                  w_apply;
    logic [ELEM_WIDTH-1:0] w_key;
    logic [ELEM_WIDTH-1:0] w_wdata;
    olte_pkg::t_cell_op    w_cell_op;
    logic [ELEM_WIDTH-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]   w_match;
    logic [CAPACITY-1:0]   w_first;
    logic [CNT_W-1:0]      w_first_idx;
    logic                  w_found;
    logic [ELEM_WIDTH-1:0] w_sel;
    logic signed [ELEM_WIDTH-1:0] w_sel_s;
    logic [CMP_W-1:0]      w_pos;
    logic [CMP_W-1:0]      w_pos_m1;
    logic [CMP_W-1:0]      w_cnt;
    logic                  w_pos_in_list;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_apply  = (r_state == S_APPLY) && (!r_out_valid || !i_stall);
    assign w_key    = ELEM_WIDTH'($unsigned(i_in.value_in));
    assign w_wdata  = ELEM_WIDTH'($unsigned(r_req.value_in));
    assign w_cell_op = w_apply ? r_op : olte_pkg::OP_NONE;

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEM_WIDTH-1:0] w_left;
        logic [ELEM_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end
        olte_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_match_en (w_accept),
            .i_key      (w_key),
            .i_count    (r_count),
            .i_op       (w_cell_op),
            .i_tgt      (r_tgt),
            .i_wdata    (w_wdata),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_value    (w_val[g]),
            .o_match    (w_match[g])
        );
    end

    // first match
    assign w_first = w_match & (~w_match + CAPACITY'(1));
    assign w_found = |w_match;

    always_comb begin
        w_first_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_first_idx = w_first_idx | CNT_W'(i);
            end
        end
    end

    // element at the target slot
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == r_tgt) begin
                w_sel = w_sel | w_val[i];
            end
        end
    end
    assign w_sel_s = w_sel;

    assign w_pos         = CMP_W'(r_req.position);
    assign w_pos_m1      = w_pos - CMP_W'(1);
    assign w_cnt         = CMP_W'(r_count);
    assign w_pos_in_list = (w_pos != '0) && (w_pos <= w_cnt);

    always_comb begin
        n_new_count = r_count;
        n_tgt       = '0;
        n_fidx      = '0;
        n_op        = olte_pkg::OP_NONE;
        n_status    = olte_pkg::ST_OK;
        n_rd        = 1'b0;
        case (r_req.action)
            olte_pkg::A_READ: begin
                if (w_pos_in_list) begin
                    n_tgt = CNT_W'(w_pos_m1);
                    n_rd  = 1'b1;
                end else begin
                    n_status = olte_pkg::ST_RANGE;
                end
            end
            olte_pkg::A_FIND: begin
                if (w_found) begin
                    n_fidx = w_first_idx;
                end else begin
                    n_status = olte_pkg::ST_NOTFOUND;
                end
            end
            olte_pkg::A_MODIFY: begin
                if (w_pos != '0 && w_pos <= CAP_C) begin
                    n_tgt = CNT_W'(w_pos_m1);
                    n_op  = olte_pkg::OP_WRITE;
                end else begin
                    n_status = olte_pkg::ST_RANGE;
                end
            end
            olte_pkg::A_INS_FRONT, olte_pkg::A_INS_BACK: begin
                if (w_cnt >= CAP_C) begin
                    n_status = olte_pkg::ST_FULL;
                end else begin
                    n_tgt       = (r_req.action == olte_pkg::A_INS_BACK) ? r_count : '0;
                    n_op        = olte_pkg::OP_INSERT;
                    n_new_count = r_count + CNT_W'(1);
                end
            end
            olte_pkg::A_INS_AT: begin
                if (!w_pos_in_list) begin
                    n_status = olte_pkg::ST_RANGE;
                end else if (w_cnt >= CAP_C) begin
                    n_status = olte_pkg::ST_FULL;
                end else begin
                    n_tgt       = CNT_W'(w_pos_m1);
                    n_op        = olte_pkg::OP_INSERT;
                    n_new_count = r_count + CNT_W'(1);
                end
            end
            olte_pkg::A_DEL_AT: begin
                if (w_pos_in_list) begin
                    n_tgt       = CNT_W'(w_pos_m1);
                    n_op        = olte_pkg::OP_DELETE;
                    n_rd        = 1'b1;
                    n_new_count = r_count - CNT_W'(1);
                end else begin
                    n_status = olte_pkg::ST_RANGE;
                end
            end
            olte_pkg::A_DEL_VALUE: begin
                if (w_found) begin
                    n_tgt       = w_first_idx;
                    n_op        = olte_pkg::OP_DELETE;
                    n_rd        = 1'b1;
                    n_new_count = r_count - CNT_W'(1);
                end else begin
                    n_status = olte_pkg::ST_NOTFOUND;
                end
            end
            olte_pkg::A_CLEAR: begin
                n_new_count = '0;
            end
            default: begin
                n_status = olte_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_LOCATE;
                    end
                end
                S_LOCATE: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_apply) begin
                        r_state <= S_IDLE;
                        r_count <= r_new_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_apply) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in;
        end
        if (r_state == S_LOCATE) begin
            r_new_count <= n_new_count;
            r_tgt       <= n_tgt;
            r_fidx      <= n_fidx;
            r_op        <= n_op;
            r_status    <= n_status;
            r_rd        <= n_rd;
        end
        if (w_apply) begin
            r_out.status      <= r_status;
            r_out.value_out   <= r_rd ? olte_pkg::VALUE_W'(w_sel_s) : '0;
            r_out.found_index <= olte_pkg::FIDX_W'(r_fidx);
            r_out.list_length <= olte_pkg::LEN_W'(r_new_count);
            r_out.is_empty    <= (r_new_count == '0);
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CAP_C)
        else $error("list length above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply && r_op == olte_pkg::OP_INSERT) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply && r_op == olte_pkg::OP_DELETE) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("delete did not shrink the list by one");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_apply && r_status == olte_pkg::ST_FULL) |-> (CMP_W'(r_count) == CAP_C))
        else $error("full status on a list below capacity");

endmodule
`default_nettype wire

### verif/ordered_list_table_engine_test.sv
// ============================================================================
// ordered_list_table_engine_test
// self-checking testbench of the ordered list table engine: requests are
// driven with random idle gaps and response stalls, each transaction is
// predicted by a behavioral list model and every result is checked field by
// field in order
// ============================================================================
module ordered_list_table_engine_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = olte_pkg::DEF_CAPACITY;
    localparam int ACT_W        = olte_pkg::ACTION_W;
    localparam int POS_MAX      = (1 << olte_pkg::POS_W) - 1;
    localparam int POOL_SIZE    = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [ACT_W-1:0] ACTION_MAX    = '1;
    localparam logic [ACT_W-1:0] ACTION_UNUSED = olte_pkg::A_CLEAR + 1'b1;

    localparam logic signed [olte_pkg::VALUE_W-1:0] VAL_MAX =
        {1'b0, {(olte_pkg::VALUE_W-1){1'b1}}};
    localparam logic signed [olte_pkg::VALUE_W-1:0] VAL_MIN =
        {1'b1, {(olte_pkg::VALUE_W-1){1'b0}}};

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           i_stall = 1'b0;
    olte_pkg::t_req i_in    = '0;
    logic           o_stall;
    logic           o_valid;
    olte_pkg::t_rsp o_out;

    // list model state
    logic signed [olte_pkg::VALUE_W-1:0] list_cells [CAP];
    int                                  list_len;

    olte_pkg::t_rsp                      pending_rsp [$];
    logic signed [olte_pkg::VALUE_W-1:0] value_pool [POOL_SIZE];
    int                                  error_count = 0;
    int                                  req_idle_pct = 0;
    int                                  stall_pct = 0;

    ordered_list_table_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 2);
        if (roll < 93) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // ------------------------------------------------------------------
    // list model
    // ------------------------------------------------------------------
    function automatic int find_value(logic signed [olte_pkg::VALUE_W-1:0] v);
        for (int i = 0; i < list_len; i++) begin
            if (list_cells[i] == v) return i;
        end
        return -1;
    endfunction

    function automatic void insert_cell(int idx, logic signed [olte_pkg::VALUE_W-1:0] v);
        for (int i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
        list_cells[idx] = v;
        list_len++;
    endfunction

    function automatic logic signed [olte_pkg::VALUE_W-1:0] remove_cell(int idx);
        logic signed [olte_pkg::VALUE_W-1:0] v;
        v = list_cells[idx];
        for (int i = idx; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
        list_len--;
        return v;
    endfunction

    function automatic olte_pkg::t_rsp apply_request(olte_pkg::t_req r);
        olte_pkg::t_rsp rsp;
        int             p;
        int             idx;
        rsp = '0;
        p   = r.position;
        case (r.action)
            olte_pkg::A_READ: begin
                if (p >= 1 && p <= list_len) rsp.value_out = list_cells[p-1];
                else rsp.status = olte_pkg::ST_RANGE;
            end
            olte_pkg::A_FIND: begin
                idx = find_value(r.value_in);
                if (idx >= 0) rsp.found_index = idx[olte_pkg::FIDX_W-1:0];
                else rsp.status = olte_pkg::ST_NOTFOUND;
            end
            olte_pkg::A_MODIFY: begin
                if (p >= 1 && p <= CAP) list_cells[p-1] = r.value_in;
                else rsp.status = olte_pkg::ST_RANGE;
            end
            olte_pkg::A_INS_FRONT: begin
                if (list_len >= CAP) rsp.status = olte_pkg::ST_FULL;
                else insert_cell(0, r.value_in);
            end
            olte_pkg::A_INS_BACK: begin
                if (list_len >= CAP) rsp.status = olte_pkg::ST_FULL;
                else insert_cell(list_len, r.value_in);
            end
            olte_pkg::A_INS_AT: begin
                if (p < 1 || p > list_len) rsp.status = olte_pkg::ST_RANGE;
                else if (list_len >= CAP) rsp.status = olte_pkg::ST_FULL;
                else insert_cell(p - 1, r.value_in);
            end
            olte_pkg::A_DEL_AT: begin
                if (p >= 1 && p <= list_len) rsp.value_out = remove_cell(p - 1);
                else rsp.status = olte_pkg::ST_RANGE;
            end
            olte_pkg::A_DEL_VALUE: begin
                idx = find_value(r.value_in);
                if (idx >= 0) rsp.value_out = remove_cell(idx);
                else rsp.status = olte_pkg::ST_NOTFOUND;
            end
            olte_pkg::A_CLEAR: list_len = 0;
            default: ;
        endcase
        rsp.list_length = list_len[olte_pkg::LEN_W-1:0];
        rsp.is_empty    = (list_len == 0);
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_request(logic [ACT_W-1:0] act, int pos,
                                logic signed [olte_pkg::VALUE_W-1:0] val);
        olte_pkg::t_req r;
        r.action   = act;
        r.position = pos[olte_pkg::POS_W-1:0];
        r.value_in = val;
        if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
            i_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_rsp.push_back(apply_request(r));
    endtask

    // ------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------
    initial begin : rsp_stall_gen
        int n;
        forever begin
            @(posedge i_clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                n = pick_gap();
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(string field, logic [olte_pkg::VALUE_W-1:0] exp_v,
                               logic [olte_pkg::VALUE_W-1:0] got_v);
        if (got_v !== exp_v)
            note_error($sformatf("%s mismatch: expected %h, got %h", field, exp_v, got_v));
    endtask

    always @(posedge i_clk) begin : rsp_check
        olte_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp.size() == 0) begin
                note_error($sformatf("unexpected transaction %h", o_out));
            end else begin
                exp_rsp = pending_rsp.pop_front();
                check_field("status", exp_rsp.status, o_out.status);
                check_field("value_out", exp_rsp.value_out, o_out.value_out);
                check_field("found_index", exp_rsp.found_index, o_out.found_index);
                check_field("list_length", exp_rsp.list_length, o_out.list_length);
                check_field("is_empty", exp_rsp.is_empty, o_out.is_empty);
            end
        end
    end

    // ------------------------------------------------------------------
    // random item selection
    // ------------------------------------------------------------------
    function automatic logic [ACT_W-1:0] pick_action(bit grow);
        int roll;
        int p_ins;
        int p_del;
        p_ins = grow ? 55 : 20;
        p_del = grow ? 10 : 40;
        roll  = $urandom_range(0, 99);
        if (roll < 2) return ACT_W'($urandom_range(ACTION_UNUSED, ACTION_MAX));
        if (roll < 4 && !grow) return olte_pkg::A_CLEAR;
        roll = $urandom_range(0, 99);
        if (roll < p_ins) begin
            case ($urandom_range(0, 2))
                0:       return olte_pkg::A_INS_FRONT;
                1:       return olte_pkg::A_INS_BACK;
                default: return olte_pkg::A_INS_AT;
            endcase
        end
        if (roll < p_ins + p_del) begin
            return $urandom_range(0, 1) ? olte_pkg::A_DEL_AT : olte_pkg::A_DEL_VALUE;
        end
        case ($urandom_range(0, 2))
            0:       return olte_pkg::A_READ;
            1:       return olte_pkg::A_FIND;
            default: return olte_pkg::A_MODIFY;
        endcase
    endfunction

    function automatic int pick_position();
        if ($urandom_range(0, 99) < 65 && list_len > 0) return $urandom_range(1, list_len);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return list_len + 1;
            2:       return CAP;
            3:       return CAP + 1;
            4:       return POS_MAX;
            default: return $urandom_range(0, POS_MAX);
        endcase
    endfunction

    function automatic logic signed [olte_pkg::VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30 && list_len > 0) return list_cells[$urandom_range(0, list_len - 1)];
        if (roll < 60) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_list();
        req_idle_pct = 0;
        stall_pct    = 0;
        send_request(olte_pkg::A_READ, 1, 0);
        send_request(olte_pkg::A_FIND, 0, 0);
        send_request(olte_pkg::A_DEL_AT, 1, 0);
        send_request(olte_pkg::A_DEL_VALUE, 0, 0);
        send_request(olte_pkg::A_INS_AT, 1, 5);
        send_request(olte_pkg::A_CLEAR, 0, 0);
    endtask

    task automatic test_edit_ops();
        req_idle_pct = 30;
        stall_pct    = 25;
        send_request(olte_pkg::A_INS_BACK, 0, VAL_MAX);
        send_request(olte_pkg::A_INS_FRONT, 0, VAL_MIN);
        send_request(olte_pkg::A_INS_AT, 2, -1);
        send_request(olte_pkg::A_INS_AT, 3, 0);
        send_request(olte_pkg::A_INS_AT, 5, 7);
        send_request(olte_pkg::A_READ, 0, 0);
        send_request(olte_pkg::A_READ, 4, 0);
        send_request(olte_pkg::A_READ, 1, 0);
        send_request(olte_pkg::A_MODIFY, 2, 1);
        send_request(olte_pkg::A_MODIFY, 0, 3);
        send_request(olte_pkg::A_MODIFY, CAP + 1, 3);
        // hidden cell beyond the length
        send_request(olte_pkg::A_MODIFY, CAP, 32'h5A5A5A5A);
        send_request(olte_pkg::A_FIND, 0, 32'h5A5A5A5A);
        send_request(olte_pkg::A_FIND, 0, VAL_MAX);
        send_request(olte_pkg::A_DEL_VALUE, 0, 1);
        send_request(olte_pkg::A_DEL_AT, 3, 0);
        send_request(olte_pkg::A_READ, POS_MAX, 0);
        send_request(ACTION_MAX, POS_MAX, -1);
        send_request(ACTION_UNUSED, 1, 0);
        send_request(olte_pkg::A_CLEAR, 0, 0);
    endtask

    task automatic test_capacity_limit();
        logic signed [olte_pkg::VALUE_W-1:0] v;
        req_idle_pct = 20;
        stall_pct    = 20;
        while (list_len < CAP) begin
            v = $urandom();
            case ($urandom_range(0, 2))
                0:       send_request(olte_pkg::A_INS_FRONT, 0, v);
                1:       send_request(olte_pkg::A_INS_BACK, 0, v);
                default: begin
                    send_request(olte_pkg::A_INS_AT,
                                 list_len > 0 ? $urandom_range(1, list_len) : 1, v);
                end
            endcase
        end
        send_request(olte_pkg::A_INS_FRONT, 0, 1);
        send_request(olte_pkg::A_INS_BACK, 0, 2);
        send_request(olte_pkg::A_INS_AT, 1, 3);
        send_request(olte_pkg::A_INS_AT, 0, 4);
        send_request(olte_pkg::A_INS_AT, CAP, 5);
        send_request(olte_pkg::A_INS_AT, CAP + 1, 6);
        send_request(olte_pkg::A_READ, CAP, 0);
        send_request(olte_pkg::A_READ, CAP + 1, 0);
        send_request(olte_pkg::A_MODIFY, CAP, VAL_MIN);
        send_request(olte_pkg::A_FIND, 0, VAL_MIN);
        send_request(olte_pkg::A_DEL_AT, CAP, 0);
        send_request(olte_pkg::A_INS_BACK, 0, VAL_MAX);
        send_request(olte_pkg::A_DEL_VALUE, 0, list_cells[0]);
        send_request(olte_pkg::A_CLEAR, 0, 0);
    endtask

    task automatic test_random_traffic();
        bit grow;
        value_pool[0] = VAL_MAX;
        value_pool[1] = VAL_MIN;
        value_pool[2] = 0;
        value_pool[3] = -1;
        value_pool[4] = 1;
        for (int i = 5; i < POOL_SIZE; i++) value_pool[i] = $urandom();
        for (int phase = 0; phase < 8; phase++) begin
            grow = (phase % 2 == 0);
            case (phase % 3)
                0: begin
                    req_idle_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    req_idle_pct = 35;
                    stall_pct    = 30;
                end
                default: begin
                    req_idle_pct = 15;
                    stall_pct    = 60;
                end
            endcase
            for (int n = 0; n < (grow ? 64 : 36); n++)
                send_request(pick_action(grow), pick_position(), pick_value());
        end
    endtask

    initial begin
        for (int i = 0; i < CAP; i++) list_cells[i] = '0;
        list_len = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_edit_ops();
        test_capacity_limit();
        test_random_traffic();
        i_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
sv/olte_pkg.sv
sv/olte_cell.sv
sv/ordered_list_table_engine.sv
verif/ordered_list_table_engine_test.sv
